// File: src/lbbf_pkg.sv
// Shared types, character codes and control signal groups for the line buffer filter.
package lbbf_pkg;

    // Input opcodes
    localparam logic       OP_DATA  = 1'b0;
    localparam logic       OP_FLUSH = 1'b1;

    // Character codes with special meaning
    localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
    localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;

    typedef struct packed {
        logic       opcode;
        logic [7:0] in_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT,
        ST_PEND
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic ram_wr;      // write a byte at the fill position
        logic wr_sel_pend; // written byte comes from the pending register
        logic fill_inc;
        logic fill_dec;
        logic fill_clr;
        logic idx_clr;
        logic idx_inc;
        logic rd_en;       // read the store at the drain index
        logic pend_load;   // capture the incoming byte for later
        logic out_load;    // load the output register
        logic out_sel_bs;  // output register takes a lone backspace
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic in_is_flush;
        logic in_is_bs;
        logic in_is_nl;
        logic pend_is_nl;
        logic fill_zero;
        logic fill_full;
        logic last_rd;     // current drain index is the final buffered byte
        logic out_free;    // output register can take a new transaction
    } t_dp_stat;

endpackage

// File: src/lbbf_ram.sv
// Generic single write port, single read port RAM with registered read data.
module lbbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port, holds its data while not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/lbbf_datapath.sv
// Datapath: line store, fill count, drain index, pending byte and output register.
module lbbf_datapath #(
    parameter int LINE_DEPTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lbbf_pkg::t_in_item  i_in_data,
    input  lbbf_pkg::t_dp_cmd   i_cmd,
    output lbbf_pkg::t_dp_stat  o_stat,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lbbf_pkg::t_out_item o_out_data
);

    localparam int AW = $clog2(LINE_DEPTH);
    localparam int CW = $clog2(LINE_DEPTH + 1);

    logic [CW-1:0]       r_fill, n_fill;
    logic [CW-1:0]       r_idx, n_idx;
    logic [7:0]          r_pend_byte;
    lbbf_pkg::t_out_item r_out, n_out;
    logic                r_out_valid, n_out_valid;

    logic [7:0] wr_data;
    logic [7:0] rd_data;
    logic [CW-1:0] idx_plus;

    // Line store
    assign wr_data = i_cmd.wr_sel_pend ? r_pend_byte : i_in_data.in_byte;

    lbbf_ram #(
        .WIDTH(8),
        .DEPTH(LINE_DEPTH)
    ) u_store (
        .i_clk    (i_clk),
        .i_wr_en  (i_cmd.ram_wr),
        .i_wr_addr(r_fill[AW-1:0]),
        .i_wr_data(wr_data),
        .i_rd_en  (i_cmd.rd_en),
        .i_rd_addr(r_idx[AW-1:0]),
        .o_rd_data(rd_data)
    );

    assign idx_plus = r_idx + CW'(1);

    // Report status
    always_comb begin
        o_stat.in_is_flush = (i_in_data.opcode == lbbf_pkg::OP_FLUSH);
        o_stat.in_is_bs    = (i_in_data.in_byte == lbbf_pkg::CHAR_BACKSPACE);
        o_stat.in_is_nl    = (i_in_data.in_byte == lbbf_pkg::CHAR_NEWLINE);
        o_stat.pend_is_nl  = (r_pend_byte == lbbf_pkg::CHAR_NEWLINE);
        o_stat.fill_zero   = (r_fill == '0);
        o_stat.fill_full   = (r_fill == CW'(LINE_DEPTH));
        o_stat.last_rd     = (idx_plus == r_fill);
        o_stat.out_free    = !r_out_valid || i_out_ready;
    end

    // Advance fill count and drain index
    always_comb begin
        n_fill = r_fill;
        if (i_cmd.fill_clr) begin
            n_fill = '0;
        end else if (i_cmd.fill_inc) begin
            n_fill = r_fill + CW'(1);
        end else if (i_cmd.fill_dec) begin
            n_fill = r_fill - CW'(1);
        end
        n_idx = r_idx;
        if (i_cmd.idx_clr) begin
            n_idx = '0;
        end else if (i_cmd.idx_inc) begin
            n_idx = idx_plus;
        end
    end

    // Load or drop the output transaction
    always_comb begin
        n_out = r_out;
        if (i_cmd.out_load) begin
            if (i_cmd.out_sel_bs) begin
                n_out.out_byte = lbbf_pkg::CHAR_BACKSPACE;
                n_out.last     = 1'b1;
            end else begin
                n_out.out_byte = rd_data;
                n_out.last     = o_stat.last_rd;
            end
        end
        if (i_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill      <= n_fill;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (i_cmd.pend_load) begin
            r_pend_byte <= i_in_data.in_byte;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: src/lbbf_controller.sv
// Controller: state machine that sequences buffering, drains and the held byte.
module lbbf_controller (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  lbbf_pkg::t_dp_stat i_stat,
    output lbbf_pkg::t_dp_cmd  o_cmd
);

    lbbf_pkg::t_state r_state, n_state;
    logic             r_pend, n_pend;
    logic             accept;

    assign o_in_ready = (r_state == lbbf_pkg::ST_IDLE) && i_stat.out_free;
    assign accept     = o_in_ready && i_in_valid;

    // Next state and pending flag
    always_comb begin
        n_state = r_state;
        n_pend  = r_pend;
        unique case (r_state)
            lbbf_pkg::ST_IDLE: begin
                if (accept) begin
                    priority if (i_stat.in_is_flush) begin
                        if (!i_stat.fill_zero) begin
                            n_state = lbbf_pkg::ST_READ;
                        end
                    end else if (i_stat.in_is_bs) begin
                        n_state = lbbf_pkg::ST_IDLE;
                    end else if (i_stat.fill_full) begin
                        n_pend  = 1'b1;
                        n_state = lbbf_pkg::ST_READ;
                    end else if (i_stat.in_is_nl) begin
                        n_state = lbbf_pkg::ST_READ;
                    end else begin
                        n_state = lbbf_pkg::ST_IDLE;
                    end
                end
            end
            lbbf_pkg::ST_READ: begin
                n_state = lbbf_pkg::ST_EMIT;
            end
            lbbf_pkg::ST_EMIT: begin
                if (i_stat.out_free) begin
                    if (!i_stat.last_rd) begin
                        n_state = lbbf_pkg::ST_READ;
                    end else if (r_pend) begin
                        n_state = lbbf_pkg::ST_PEND;
                    end else begin
                        n_state = lbbf_pkg::ST_IDLE;
                    end
                end
            end
            lbbf_pkg::ST_PEND: begin
                n_pend  = 1'b0;
                n_state = i_stat.pend_is_nl ? lbbf_pkg::ST_READ : lbbf_pkg::ST_IDLE;
            end
            default: begin
                n_state = lbbf_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath commands
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            lbbf_pkg::ST_IDLE: begin
                if (accept) begin
                    priority if (i_stat.in_is_flush) begin
                        o_cmd.idx_clr = !i_stat.fill_zero;
                    end else if (i_stat.in_is_bs) begin
                        if (i_stat.fill_zero) begin
                            o_cmd.out_load   = 1'b1;
                            o_cmd.out_sel_bs = 1'b1;
                        end else begin
                            o_cmd.fill_dec = 1'b1;
                        end
                    end else if (i_stat.fill_full) begin
                        o_cmd.pend_load = 1'b1;
                        o_cmd.idx_clr   = 1'b1;
                    end else begin
                        o_cmd.ram_wr   = 1'b1;
                        o_cmd.fill_inc = 1'b1;
                        o_cmd.idx_clr  = i_stat.in_is_nl;
                    end
                end
            end
            lbbf_pkg::ST_READ: begin
                o_cmd.rd_en = 1'b1;
            end
            lbbf_pkg::ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.idx_inc  = 1'b1;
                    o_cmd.fill_clr = i_stat.last_rd;
                end
            end
            lbbf_pkg::ST_PEND: begin
                o_cmd.ram_wr      = 1'b1;
                o_cmd.wr_sel_pend = 1'b1;
                o_cmd.fill_inc    = 1'b1;
                o_cmd.idx_clr     = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lbbf_pkg::ST_IDLE;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
    end

endmodule

// File: src/line_buffer_backspace_filter.sv
// Top level of the line buffer filter: controller plus datapath.
// A byte is buffered or a backspace absorbed on acceptance; a lone backspace is output
// the cycle after acceptance. A drain reads the store in the READ state, then loads the
// output register in the EMIT state, where it waits while the output is stalled;
// no input is taken until it ends. A byte on a full store is held in the pending register
// during the drain, then written in the PEND state. Reset clears the state, fill count and
// output valid; the line store is not cleared and is never read before being written.
module line_buffer_backspace_filter #(
    parameter int LINE_DEPTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lbbf_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lbbf_pkg::t_out_item o_out_data
);

    lbbf_pkg::t_dp_cmd  cmd;
    lbbf_pkg::t_dp_stat stat;

    lbbf_controller u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    lbbf_datapath #(
        .LINE_DEPTH(LINE_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

endmodule

// File: src/lbbf_checker.sv
// Port-level checker for the line buffer filter, bound to the top level.
module lbbf_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input lbbf_pkg::t_in_item  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input lbbf_pkg::t_out_item o_out_data
);

    // Hold a stalled output transaction
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output transaction dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("output payload changed while stalled");

    // Newlines and backspaces always close their run
    a_special_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.out_byte == lbbf_pkg::CHAR_NEWLINE ||
                        o_out_data.out_byte == lbbf_pkg::CHAR_BACKSPACE)
        |-> o_out_data.last)
        else $error("newline or backspace emitted without last");

    // A newline always starts a drain, so input stalls next cycle
    a_nl_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.opcode == lbbf_pkg::OP_DATA &&
        i_in_data.in_byte == lbbf_pkg::CHAR_NEWLINE |=> !o_in_ready)
        else $error("input accepted during newline drain");

endmodule

bind line_buffer_backspace_filter lbbf_checker u_lbbf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_ready (o_in_ready),
    .i_in_data  (i_in_data),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_data (o_out_data)
);

// File: verif/line_buffer_backspace_filter_tb.sv
// Self-checking testbench for the line buffer filter with a line-editing scoreboard.
module line_buffer_backspace_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_DEPTH    = 32;
    localparam int ITEM_COUNT    = 470;
    localparam int CALM_FROM     = 390;     // no idling from this transaction onwards
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 200_000;

    // Track the edited line and hold the bytes each transaction must release
    class line_edit_scoreboard;
        logic [7:0]           line_bytes [LINE_DEPTH];
        int                   fill = 0;
        lbbf_pkg::t_out_item  expected_bytes [$];
        int                   errors = 0;

        // Release the buffered line as one run, marking its final byte
        function void drain_line();
            lbbf_pkg::t_out_item r;
            for (int i = 0; i < fill; i++) begin
                r.out_byte = line_bytes[i];
                r.last     = (i == fill - 1);
                expected_bytes.push_back(r);
            end
            fill = 0;
        endfunction

        function void note_char(lbbf_pkg::t_in_item item);
            lbbf_pkg::t_out_item r;
            if (item.opcode == lbbf_pkg::OP_FLUSH) begin
                drain_line();
                return;
            end
            // Erase the last byte, or pass a lone backspace straight out
            if (item.in_byte == lbbf_pkg::CHAR_BACKSPACE) begin
                if (fill > 0) begin
                    fill--;
                end else begin
                    r.out_byte = lbbf_pkg::CHAR_BACKSPACE;
                    r.last     = 1'b1;
                    expected_bytes.push_back(r);
                end
                return;
            end
            if (fill == LINE_DEPTH) begin
                drain_line();
            end
            line_bytes[fill] = item.in_byte;
            fill++;
            if (item.in_byte == lbbf_pkg::CHAR_NEWLINE) begin
                drain_line();
            end
        endfunction

        function void check_output(lbbf_pkg::t_out_item got);
            lbbf_pkg::t_out_item want;
            if (expected_bytes.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("ERROR: unexpected output byte %02h last %0b",
                             got.out_byte, got.last);
                end
                return;
            end
            want = expected_bytes.pop_front();
            if (got.out_byte !== want.out_byte || got.last !== want.last) begin
                errors++;
                if (errors <= 10) begin
                    $display("ERROR: expected byte %02h last %0b, got byte %02h last %0b",
                             want.out_byte, want.last, got.out_byte, got.last);
                end
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    lbbf_pkg::t_in_item  i_in_data;
    logic                o_out_valid;
    logic                i_out_ready;
    lbbf_pkg::t_out_item o_out_data;

    line_edit_scoreboard book = new;
    logic idling = 1'b0;
    int   stall_left = 0;
    int   items_sent = 0;

    line_buffer_backspace_filter #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Stall the output side in short bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (idling && $urandom_range(0, 5) == 0) begin
            stall_left  <= int'($urandom_range(0, 3));
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Note accepted characters before checking released bytes
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                book.note_char(i_in_data);
            end
            if (o_out_valid && i_out_ready) begin
                book.check_output(o_out_data);
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Some tests failed");
        $finish;
    end

    // Offer one transaction, possibly after a short gap, and hold it until accepted
    task automatic send_item(input logic op, input logic [7:0] ch);
        lbbf_pkg::t_in_item item;
        item.opcode  = op;
        item.in_byte = ch;
        if (idling && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] ch);
        send_item(lbbf_pkg::OP_DATA, ch);
    endtask

    // Draw a character with no editing meaning
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while (c == lbbf_pkg::CHAR_BACKSPACE || c == lbbf_pkg::CHAR_NEWLINE);
        return c;
    endfunction

    initial begin
        int kind;
        int len;
        int line_no;

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idling  <= 1'b1;

        // Directed: empty-store cases, erasing, flush ignoring its byte, byte extremes
        send_item(lbbf_pkg::OP_FLUSH, 8'hFF);
        send_byte(lbbf_pkg::CHAR_BACKSPACE);
        send_byte(8'h41);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(lbbf_pkg::CHAR_BACKSPACE);
        send_item(lbbf_pkg::OP_FLUSH, lbbf_pkg::CHAR_NEWLINE);
        send_byte(8'h7E);
        send_byte(lbbf_pkg::CHAR_BACKSPACE);
        send_byte(lbbf_pkg::CHAR_BACKSPACE);
        send_byte(8'h80);
        send_byte(lbbf_pkg::CHAR_NEWLINE);
        send_byte(lbbf_pkg::CHAR_NEWLINE);
        send_item(lbbf_pkg::OP_FLUSH, 8'h00);
        send_byte(8'h55);
        send_byte(8'hAA);
        send_item(lbbf_pkg::OP_FLUSH, lbbf_pkg::CHAR_BACKSPACE);

        // Random lines; the first two always reach a full store
        line_no = 0;
        while (items_sent < ITEM_COUNT) begin
            if (items_sent >= CALM_FROM) begin
                idling <= 1'b0;
            end
            kind = (line_no < 2) ? line_no : int'($urandom_range(0, 9));
            case (kind)
                0: begin
                    // Newline on a full store
                    repeat (LINE_DEPTH) send_byte(plain_char());
                    send_byte(lbbf_pkg::CHAR_NEWLINE);
                end
                1: begin
                    // Overflow, then end the line either way
                    repeat (LINE_DEPTH + $urandom_range(1, 8)) send_byte(plain_char());
                    if ($urandom_range(0, 1) == 0) begin
                        send_byte(lbbf_pkg::CHAR_NEWLINE);
                    end else begin
                        send_item(lbbf_pkg::OP_FLUSH, 8'($urandom_range(0, 255)));
                    end
                end
                2: begin
                    // Noise
                    repeat ($urandom_range(1, 6)) begin
                        send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                    end
                end
                3: begin
                    // Erase past the start of the line
                    len = int'($urandom_range(0, 3));
                    repeat (len) send_byte(plain_char());
                    repeat (len + $urandom_range(1, 3)) send_byte(lbbf_pkg::CHAR_BACKSPACE);
                end
                default: begin
                    len = int'($urandom_range(0, 20));
                    repeat (len) begin
                        if ($urandom_range(0, 5) == 0) begin
                            send_byte(lbbf_pkg::CHAR_BACKSPACE);
                        end else begin
                            send_byte(plain_char());
                        end
                    end
                    if ($urandom_range(0, 3) == 0) begin
                        send_item(lbbf_pkg::OP_FLUSH, 8'($urandom_range(0, 255)));
                    end else begin
                        send_byte(lbbf_pkg::CHAR_NEWLINE);
                    end
                end
            endcase
            line_no++;
        end

        // Drop valid, drain the expected bytes, then settle
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (book.expected_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (book.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
